/* rtl/bfx_pkg.sv */
// ----------------------------------------------------------------------------
// bfx_pkg
// Shared types and constants for the byte FIFO with XOR checksum and search.
// ----------------------------------------------------------------------------
`default_nettype none

package bfx_pkg;

    localparam int BYTE_W     = 8;
    localparam int FUNC_W     = 3;
    localparam int PATTERN_W  = 64;
    localparam int PLEN_W     = 4;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 3;
    localparam int FILL_W     = 8;

    localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'hFF;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 3'd0,
        FUNC_POP1   = 3'd1,
        FUNC_POP2   = 3'd2,
        FUNC_POP4   = 3'd3,
        FUNC_SEARCH = 3'd4,
        FUNC_CLEAR  = 3'd5
    } func_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ring_ctl_t;

endpackage

`default_nettype wire

/* rtl/bfx_if.sv */
// ----------------------------------------------------------------------------
// bfx_if
// Request and response channels of the byte FIFO: valid/ready plus payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfx_req_if;
    logic                              valid;
    logic                              ready;
    logic [bfx_pkg::FUNC_W-1:0]        func;
    logic [bfx_pkg::BYTE_W-1:0]        byte_in;
    logic [bfx_pkg::PATTERN_W-1:0]     pattern;
    logic [bfx_pkg::PLEN_W-1:0]        pattern_len;

    modport source (output valid, func, byte_in, pattern, pattern_len, input ready);
    modport sink   (input valid, func, byte_in, pattern, pattern_len, output ready);
endinterface

interface bfx_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [bfx_pkg::DATA_W-1:0]        read_data;
    logic                              found;
    logic [bfx_pkg::BYTE_W-1:0]        checksum;
    logic [bfx_pkg::FILL_W-1:0]        fill_count;
    logic                              underflow;
    logic                              overflow;

    modport source (output valid, read_data, found, checksum, fill_count, underflow,
                    overflow, input ready);
    modport sink   (input valid, read_data, found, checksum, fill_count, underflow,
                    overflow, output ready);
endinterface

`default_nettype wire

/* rtl/bfx_ring.sv */
// ----------------------------------------------------------------------------
// bfx_ring
// Ring store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfx_ring #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire                            clk,
    input  wire bfx_pkg::ring_ctl_t        ctl,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [bfx_pkg::BYTE_W-1:0] wr_data,
    input  wire logic [AW-1:0]             rd_addr,
    output logic [bfx_pkg::BYTE_W-1:0]     rd_data
);

    logic [bfx_pkg::BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/byte_fifo_xor_sync_search.sv */
// ----------------------------------------------------------------------------
// byte_fifo_xor_sync_search
// Circular byte FIFO with running XOR checksum, multi-byte pops and a
// pattern search, run by a small sequencer over one byte path.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | func, byte_in, pattern, pattern_len
//  rsp     | out | valid/ready | read_data, found, checksum, fill_count,
//          |     |             | underflow, overflow
//
//  Push, clear and unused codes go straight from idle to the finish state; a
//  pop passes through a read and a take state for each byte, and a search does
//  the same for each byte scanned, comparing it in the take state.
//  Reset clears pointers, fill count, checksum and sequencer; the store is
//  left as is. req.ready is high only when the sequencer is idle; a result in
//  the output register holds off not the next item's acceptance but its finish.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_fifo_xor_sync_search #(
    parameter int DEPTH       = 256,
    parameter int MAX_PATTERN = 8
) (
    input  wire       clk,
    input  wire       rst_n,
    bfx_req_if.sink   req,
    bfx_rsp_if.source rsp
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CMPW = (AW > bfx_pkg::PLEN_W) ? AW : bfx_pkg::PLEN_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_TAKE   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [bfx_pkg::BYTE_W-1:0] xor_reg, xor_next;
    logic out_valid_reg, out_valid_next;

    logic [AW-1:0]                    saved_rp_reg, saved_rp_next;
    logic [AW-1:0]                    saved_cnt_reg, saved_cnt_next;
    bfx_pkg::func_t                   func_reg, func_next;
    logic [bfx_pkg::PATTERN_W-1:0]    pat_reg, pat_next;
    logic [bfx_pkg::PLEN_W-1:0]       len_reg, len_next;
    logic [bfx_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [1:0]                       idx_reg, idx_next;
    logic [1:0]                       last_idx_reg, last_idx_next;
    logic [bfx_pkg::DATA_W-1:0]       data_reg, data_next;
    logic                             found_reg, found_next;
    logic                             under_reg, under_next;
    logic                             over_reg, over_next;

    logic [bfx_pkg::DATA_W-1:0]       o_data_reg, o_data_next;
    logic                             o_found_reg, o_found_next;
    logic [bfx_pkg::BYTE_W-1:0]       o_sum_reg, o_sum_next;
    logic [bfx_pkg::FILL_W-1:0]       o_fill_reg, o_fill_next;
    logic                             o_under_reg, o_under_next;
    logic                             o_over_reg, o_over_next;

    bfx_pkg::ring_ctl_t               ring_ctl;
    logic [bfx_pkg::BYTE_W-1:0]       rd_data;

    logic                             accept;
    bfx_pkg::func_t                   req_func;
    logic [bfx_pkg::PLEN_W-1:0]       len_eff;
    logic [AW-1:0]                    rp_inc;
    logic [AW-1:0]                    wp_inc;
    logic                             empty;
    logic [bfx_pkg::BYTE_W-1:0]       byte_val;
    logic [bfx_pkg::BYTE_W-1:0]       want;
    logic                             slot_free;

    assign accept    = req.valid && req.ready;
    assign req_func  = bfx_pkg::func_t'(req.func);
    assign len_eff   = (req.pattern_len > bfx_pkg::PLEN_W'(MAX_PATTERN))
                       ? bfx_pkg::PLEN_W'(MAX_PATTERN) : req.pattern_len;
    assign rp_inc    = (rp_reg == LAST_ADDR) ? '0 : rp_reg + 1'b1;
    assign wp_inc    = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
    assign empty     = (cnt_reg == '0);
    assign byte_val  = empty ? bfx_pkg::EMPTY_BYTE : rd_data;
    assign want      = pat_reg[{pos_reg, 3'b000} +: bfx_pkg::BYTE_W];
    assign slot_free = !out_valid_reg || rsp.ready;

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = o_data_reg;
    assign rsp.found      = o_found_reg;
    assign rsp.checksum   = o_sum_reg;
    assign rsp.fill_count = o_fill_reg;
    assign rsp.underflow  = o_under_reg;
    assign rsp.overflow   = o_over_reg;

    bfx_ring #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .ctl     (ring_ctl),
        .wr_addr (wp_reg),
        .wr_data (req.byte_in),
        .rd_addr (rp_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        xor_next       = xor_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        saved_rp_next  = saved_rp_reg;
        saved_cnt_next = saved_cnt_reg;
        func_next      = func_reg;
        pat_next       = pat_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        data_next      = data_reg;
        found_next     = found_reg;
        under_next     = under_reg;
        over_next      = over_reg;
        o_data_next    = o_data_reg;
        o_found_next   = o_found_reg;
        o_sum_next     = o_sum_reg;
        o_fill_next    = o_fill_reg;
        o_under_next   = o_under_reg;
        o_over_next    = o_over_reg;
        ring_ctl       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next     = req_func;
                    pat_next      = req.pattern;
                    len_next      = len_eff;
                    pos_next      = '0;
                    idx_next      = '0;
                    data_next     = '0;
                    found_next    = 1'b0;
                    under_next    = 1'b0;
                    over_next     = 1'b0;
                    last_idx_next = 2'd0;
                    state_next    = ST_FINISH;
                    unique case (req_func)
                        bfx_pkg::FUNC_PUSH:
                        begin
                            if (cnt_reg == LAST_ADDR)
                            begin
                                over_next = 1'b1;
                            end
                            else
                            begin
                                ring_ctl.wr_en = 1'b1;
                                wp_next        = wp_inc;
                                cnt_next       = cnt_reg + 1'b1;
                            end
                        end
                        bfx_pkg::FUNC_POP1:
                        begin
                            state_next = ST_READ;
                        end
                        bfx_pkg::FUNC_POP2:
                        begin
                            last_idx_next = 2'd1;
                            state_next    = ST_READ;
                        end
                        bfx_pkg::FUNC_POP4:
                        begin
                            last_idx_next = 2'd3;
                            state_next    = ST_READ;
                        end
                        bfx_pkg::FUNC_SEARCH:
                        begin
                            // skip when the pattern is empty or longer than the fill
                            if ((len_eff != '0) && (CMPW'(cnt_reg) >= CMPW'(len_eff)))
                            begin
                                saved_rp_next  = rp_reg;
                                saved_cnt_next = cnt_reg;
                                state_next     = ST_READ;
                            end
                        end
                        bfx_pkg::FUNC_CLEAR:
                        begin
                            xor_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                ring_ctl.rd_en = !empty;
                state_next     = ST_TAKE;
            end
            ST_TAKE:
            begin
                if (!empty)
                begin
                    rp_next  = rp_inc;
                    cnt_next = cnt_reg - 1'b1;
                    xor_next = xor_reg ^ rd_data;
                end
                if (func_reg == bfx_pkg::FUNC_SEARCH)
                begin
                    state_next = ST_READ;
                    if (rd_data == want)
                    begin
                        if ((bfx_pkg::PLEN_W'(pos_reg) + 1'b1) == len_reg)
                        begin
                            found_next = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        pos_next = '0;
                    end
                    // out of bytes without a match: rewind, keep the checksum
                    if ((state_next != ST_FINISH) && (cnt_reg == AW'(1)))
                    begin
                        rp_next    = saved_rp_reg;
                        cnt_next   = saved_cnt_reg;
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    if (empty)
                    begin
                        under_next = 1'b1;
                    end
                    data_next = data_reg
                                | (bfx_pkg::DATA_W'(byte_val) << {idx_reg, 3'b000});
                    if (idx_reg == last_idx_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    o_data_next    = data_reg;
                    o_found_next   = found_reg;
                    o_sum_next     = xor_reg;
                    o_fill_next    = bfx_pkg::FILL_W'(cnt_reg);
                    o_under_next   = under_reg;
                    o_over_next    = over_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            xor_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            xor_reg       <= xor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        saved_rp_reg  <= saved_rp_next;
        saved_cnt_reg <= saved_cnt_next;
        func_reg      <= func_next;
        pat_reg       <= pat_next;
        len_reg       <= len_next;
        pos_reg       <= pos_next;
        idx_reg       <= idx_next;
        last_idx_reg  <= last_idx_next;
        data_reg      <= data_next;
        found_reg     <= found_next;
        under_reg     <= under_next;
        over_reg      <= over_next;
        o_data_reg    <= o_data_next;
        o_found_reg   <= o_found_next;
        o_sum_reg     <= o_sum_next;
        o_fill_reg    <= o_fill_next;
        o_under_reg   <= o_under_next;
        o_over_reg    <= o_over_next;
    end

`ifndef NO_ASSERTIONS
    a_fill_matches_pointers: assert property (@(posedge clk) disable iff (!rst_n)
        (AW+1)'(cnt_reg) == (({1'b0, wp_reg} + (AW+1)'(DEPTH) - {1'b0, rp_reg})
                             - (({1'b0, wp_reg} >= {1'b0, rp_reg}) ? (AW+1)'(DEPTH)
                                                                   : (AW+1)'(0))))
        else $error("fill count disagrees with pointers");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.func == bfx_pkg::FUNC_PUSH) && (cnt_reg != LAST_ADDR))
        |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("accepted push did not add a byte");

    a_found_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.found && ((rsp.read_data != '0) || rsp.underflow
                                      || rsp.overflow)))
        else $error("search result carries pop or push status");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && slot_free) |=> (rsp.valid && req.ready))
        else $error("finished item not presented");
`endif

endmodule

`default_nettype wire
